[hw/rtl/atld_pkg.sv]
// Shared types, constants and the arctangent table of the azimuth travel limit detector.
package atld_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int MAXT_W    = 17;
    localparam int TRAVEL_W  = 18;
    localparam int TDATA_O_W = ((TRAVEL_W + 7) / 8) * 8;

    localparam logic [MAXT_W-1:0] MAXT_RST = 17'h10000;

    // normalised magnitudes carry their leading one at bit NORM_TOP
    localparam int NORM_TOP = 29;
    localparam int NORM_W   = NORM_TOP + 1;
    localparam int CORD_W   = 34;
    localparam int Z_W      = 32;

    localparam logic [Z_W-1:0] HALF_TURN_Z = 32'h8000_0000;

    typedef struct packed {
        logic uneg;    // x > 0
        logic vneg;    // y > 0
        logic origin;  // x = y = 0
    } atld_quad_t;

    // atan(2^-i) in 1/2^32 turn, truncated
    function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic [Z_W-1:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051D;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2E;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517C;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A2F;
                5'd19: r = 32'h00000517;
                5'd20: r = 32'h0000028B;
                5'd21: r = 32'h00000145;
                5'd22: r = 32'h000000A2;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000028;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000002;
                5'd29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/atld_norm.sv]
// Bit-serial normaliser: shifts both magnitudes one place a cycle until the larger leads at bit 29.
module atld_norm #(
    parameter int COORD_BITS = atld_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COORD_BITS-1:0]         ax,
    input  logic [COORD_BITS-1:0]         ay,
    output logic                          done,
    output logic [atld_pkg::NORM_W-1:0]   nx,
    output logic [atld_pkg::NORM_W-1:0]   ny
);

    // at least one bit above the normalised field
    localparam int NW = ((COORD_BITS > atld_pkg::NORM_W) ? COORD_BITS : atld_pkg::NORM_W) + 1;

    logic [NW-1:0] bx_reg;
    logic [NW-1:0] by_reg;
    logic [NW-1:0] big;
    logic          run_reg;
    logic          done_reg;
    logic          too_big;

    assign big     = bx_reg | by_reg;
    assign too_big = |big[NW-1:atld_pkg::NORM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && !too_big && big[atld_pkg::NORM_TOP])
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bx_reg <= {{(NW-COORD_BITS){1'b0}}, ax};
            by_reg <= {{(NW-COORD_BITS){1'b0}}, ay};
        end
        else if (run_reg)
        begin
            if (too_big)
            begin
                bx_reg <= bx_reg >> 1;
                by_reg <= by_reg >> 1;
            end
            else if (!big[atld_pkg::NORM_TOP])
            begin
                bx_reg <= bx_reg << 1;
                by_reg <= by_reg << 1;
            end
        end
    end

    assign done = done_reg;
    assign nx   = bx_reg[atld_pkg::NORM_W-1:0];
    assign ny   = by_reg[atld_pkg::NORM_W-1:0];

endmodule

[hw/rtl/atld_cordic.sv]
// Iterative vectoring CORDIC, one step a cycle, with quadrant fold and rounding to the angle width.
module atld_cordic #(
    parameter int ANGLE_BITS   = atld_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = atld_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  atld_pkg::atld_quad_t          quad,
    input  logic [atld_pkg::NORM_W-1:0]   nx,
    input  logic [atld_pkg::NORM_W-1:0]   ny,
    output logic                          done,
    output logic [ANGLE_BITS-1:0]         angle
);

    localparam int SW = $clog2(CORDIC_STEPS);
    localparam logic [SW-1:0] LAST_STEP = SW'(CORDIC_STEPS - 1);
    localparam logic [atld_pkg::Z_W:0] Q_HALF =
        (ANGLE_BITS >= atld_pkg::Z_W) ? '0 : (33'd1 << (atld_pkg::Z_W - 1 - ANGLE_BITS));

    logic signed [atld_pkg::CORD_W-1:0] cx_reg;
    logic signed [atld_pkg::CORD_W-1:0] cy_reg;
    logic signed [atld_pkg::CORD_W-1:0] dx;
    logic signed [atld_pkg::CORD_W-1:0] dy;
    logic [atld_pkg::Z_W-1:0]           z_reg;
    logic [atld_pkg::Z_W-1:0]           rot;
    logic [atld_pkg::Z_W-1:0]           t_fold;
    logic [atld_pkg::Z_W:0]             t_sum;
    logic [SW-1:0]                      step_reg;
    logic                               run_reg;
    logic                               fin_reg;
    logic                               done_reg;
    atld_pkg::atld_quad_t               quad_reg;
    logic [ANGLE_BITS-1:0]              angle_reg;

    assign dx  = cy_reg >>> step_reg;
    assign dy  = cx_reg >>> step_reg;
    assign rot = atld_pkg::atan_turn(5'(step_reg));

    always_comb
    begin
        if (quad_reg.origin)
        begin
            t_fold = atld_pkg::HALF_TURN_Z;
        end
        else
        begin
            case ({quad_reg.uneg, quad_reg.vneg})
                2'b00:   t_fold = z_reg;
                2'b10:   t_fold = atld_pkg::HALF_TURN_Z - z_reg;
                2'b11:   t_fold = atld_pkg::HALF_TURN_Z + z_reg;
                default: t_fold = '0 - z_reg;
            endcase
        end
        t_sum = {1'b0, t_fold} + Q_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                run_reg  <= !quad.origin;
                fin_reg  <= quad.origin;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg   <= {{(atld_pkg::CORD_W-atld_pkg::NORM_W){1'b0}}, nx};
            cy_reg   <= {{(atld_pkg::CORD_W-atld_pkg::NORM_W){1'b0}}, ny};
            z_reg    <= '0;
            quad_reg <= quad;
        end
        else if (run_reg)
        begin
            if (!cy_reg[atld_pkg::CORD_W-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + rot;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - rot;
            end
        end
        if (fin_reg)
        begin
            angle_reg <= t_sum[atld_pkg::Z_W-1 -: ANGLE_BITS];
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

[hw/rtl/atld_track.sv]
// Track state: start and previous angle, wrap latch, travel and limit compare.
module atld_track #(
    parameter int ANGLE_BITS = atld_pkg::ANGLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           upd,
    input  logic [ANGLE_BITS-1:0]          angle,
    input  logic                           new_track,
    input  logic [atld_pkg::MAXT_W-1:0]    max_travel,
    output logic                           terminate,
    output logic [atld_pkg::TRAVEL_W-1:0]  travel
);

    localparam int DW  = ANGLE_BITS + 2;
    localparam int CMW = (DW > atld_pkg::MAXT_W) ? DW : atld_pkg::MAXT_W;
    localparam logic [DW-1:0] TURN = {2'b01, {ANGLE_BITS{1'b0}}};
    localparam logic signed [ANGLE_BITS:0] HALF_D = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] NEG_HALF_D = -HALF_D;

    typedef enum logic [1:0] {
        WRAP_NONE = 2'd0,
        WRAP_DOWN = 2'd1,
        WRAP_UP   = 2'd2
    } wrap_dir_t;

    logic                   have_start_reg;
    logic [ANGLE_BITS-1:0]  start_reg;
    logic [ANGLE_BITS-1:0]  prev_reg;
    logic                   wrapped_reg;
    wrap_dir_t              wrap_dir_reg;

    logic                   first;
    logic [DW-1:0]          now_e;
    logic [DW-1:0]          st_e;
    logic [DW-1:0]          d_abs;
    logic [DW-1:0]          d_dn;
    logic [DW-1:0]          d_up;
    logic [DW-1:0]          delta;
    logic signed [ANGLE_BITS:0] diff;
    logic                   wrap_dn;
    logic                   wrap_up;
    logic                   term;

    always_comb
    begin
        first   = !have_start_reg || new_track;
        now_e   = DW'(angle);
        st_e    = DW'(start_reg);
        d_abs   = (st_e >= now_e) ? (st_e - now_e) : (now_e - st_e);
        d_dn    = TURN + now_e - st_e;
        d_up    = TURN - now_e + st_e;
        diff    = $signed({1'b0, prev_reg}) - $signed({1'b0, angle});
        wrap_dn = (diff >= HALF_D);
        wrap_up = (diff <= NEG_HALF_D);

        if (first)
        begin
            delta = '0;
        end
        else if (wrap_up)
        begin
            delta = d_up;
        end
        else if (wrap_dn)
        begin
            delta = d_dn;
        end
        else if (!wrapped_reg)
        begin
            delta = d_abs;
        end
        else
        begin
            case (wrap_dir_reg)
                WRAP_DOWN: delta = d_dn;
                WRAP_UP:   delta = d_up;
                default:   delta = '0;
            endcase
        end
        term = CMW'(delta) > CMW'(max_travel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_start_reg <= 1'b0;
            start_reg      <= '0;
            prev_reg       <= '0;
            wrapped_reg    <= 1'b0;
            wrap_dir_reg   <= WRAP_NONE;
        end
        else if (upd)
        begin
            prev_reg <= angle;
            if (first)
            begin
                have_start_reg <= 1'b1;
                start_reg      <= angle;
                wrapped_reg    <= 1'b0;
                wrap_dir_reg   <= WRAP_NONE;
            end
            else if (term)
            begin
                wrapped_reg  <= 1'b0;
                wrap_dir_reg <= WRAP_NONE;
            end
            else if (wrap_up)
            begin
                wrapped_reg  <= 1'b1;
                wrap_dir_reg <= WRAP_UP;
            end
            else if (wrap_dn)
            begin
                wrapped_reg  <= 1'b1;
                wrap_dir_reg <= WRAP_DOWN;
            end
        end
    end

    assign terminate = term;
    assign travel    = atld_pkg::TRAVEL_W'(delta);

endmodule

[hw/rtl/azimuth_travel_limit_detector_core.sv]
// Azimuth travel limit detector: stream front end, sequencing and result register.
// Path from input transfer to result: the normaliser shifts until the larger magnitude's
//   leading one is at bit 29, then come the CORDIC steps, the quadrant fold and rounding,
//   and the track update into the result register; the origin skips shifter and CORDIC steps.
// One item is in work at a time: the input reopens when the result register loads, and
//   a result left waiting keeps the next one in the hold state until it goes.
// Reset (rst_n, async, active low) clears the track state and sets max_travel to one turn.
module azimuth_travel_limit_detector_core #(
    parameter int COORD_BITS   = atld_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS   = atld_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = atld_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input positions
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,  // pos_x, pos_y
    input  logic                                   s_axis_tuser,  // new_track
    // results
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [atld_pkg::TDATA_O_W-1:0]         m_axis_tdata,  // travel
    output logic                                   m_axis_tuser,  // terminate
    // limit register
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [atld_pkg::MAXT_W-1:0]            cfg_data       // max_travel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_CORD,
        S_HOLD
    } state_t;

    state_t                          state_reg;
    logic [atld_pkg::MAXT_W-1:0]     max_travel_reg;
    logic                            new_track_reg;
    atld_pkg::atld_quad_t            quad_reg;
    atld_pkg::atld_quad_t            quad_in;

    logic                            m_valid_reg;
    logic                            term_reg;
    logic [atld_pkg::TRAVEL_W-1:0]   travel_reg;

    logic                            in_xfer;
    logic                            out_free;
    logic                            upd;
    logic [COORD_BITS-1:0]           pos_x;
    logic [COORD_BITS-1:0]           pos_y;
    logic [COORD_BITS-1:0]           ax;
    logic [COORD_BITS-1:0]           ay;
    logic                            norm_done;
    logic [atld_pkg::NORM_W-1:0]     nx;
    logic [atld_pkg::NORM_W-1:0]     ny;
    logic                            cord_start;
    logic                            cord_done;
    logic [ANGLE_BITS-1:0]           angle;
    logic                            trk_term;
    logic [atld_pkg::TRAVEL_W-1:0]   trk_travel;

    // magnitudes of (-x, -y); the quadrant flags pick the fold after the CORDIC
    always_comb
    begin
        pos_x          = s_axis_tdata[COORD_BITS-1:0];
        pos_y          = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        ax             = pos_x[COORD_BITS-1] ? (~pos_x + 1'b1) : pos_x;
        ay             = pos_y[COORD_BITS-1] ? (~pos_y + 1'b1) : pos_y;
        quad_in.uneg   = !pos_x[COORD_BITS-1] && (|ax);
        quad_in.vneg   = !pos_y[COORD_BITS-1] && (|ay);
        quad_in.origin = !(|ax) && !(|ay);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign upd           = (state_reg == S_HOLD) && out_free;
    // origin goes straight to the fold stage; the angle is fixed at half a turn
    assign cord_start    = (in_xfer && quad_in.origin) || norm_done;

    atld_norm #(
        .COORD_BITS (COORD_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer && !quad_in.origin),
        .ax    (ax),
        .ay    (ay),
        .done  (norm_done),
        .nx    (nx),
        .ny    (ny)
    );

    atld_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .quad  (in_xfer ? quad_in : quad_reg),
        .nx    (nx),
        .ny    (ny),
        .done  (cord_done),
        .angle (angle)
    );

    atld_track #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .angle      (angle),
        .new_track  (new_track_reg),
        .max_travel (max_travel_reg),
        .terminate  (trk_term),
        .travel     (trk_travel)
    );

    // sequencer and result register; the result waits here while the next item runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && !upd)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= quad_in.origin ? S_CORD : S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    if (cord_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg   <= S_IDLE;
                        m_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            new_track_reg <= s_axis_tuser;
            quad_reg      <= quad_in;
        end
        if (upd)
        begin
            term_reg   <= trk_term;
            travel_reg <= trk_travel;
        end
    end

    // limit register, written only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_travel_reg <= atld_pkg::MAXT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_travel_reg <= cfg_data;
        end
    end

    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = term_reg;
    assign m_axis_tdata  = atld_pkg::TDATA_O_W'(travel_reg);

endmodule

[hw/rtl/atld_checker.sv]
// Port-level checker for the detector core, bound to the top level.
module atld_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [atld_pkg::TDATA_O_W-1:0]         m_axis_tdata,
    input  logic                                   m_axis_tuser
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // one item in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // every result belongs to an accepted item, at most one waiting plus one in work
    a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd3) && (!m_axis_tvalid || pend_reg != 2'd0))
        else $error("result without matching input transfer");

    // a terminate needs travel beyond the limit, which is never below zero
    a_term_travel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[atld_pkg::TRAVEL_W-1:0] != '0)
        else $error("terminate with zero travel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind azimuth_travel_limit_detector_core atld_checker u_atld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_top.sv]
// Testbench for the azimuth travel limit detector: directed table, random tracks, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int TURN        = 65536;
    localparam int HALF        = 32768;
    localparam int DRAIN       = 64;     // worst path is the longest normaliser shift run plus 16 CORDIC steps
    localparam int STALL_LIMIT = 4000;   // cycles with no transfer on any channel
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 150;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] Z_HALF = 32'h8000_0000;

    // atan(2^-i) in 1/2^32 turn, entry 0 in the lowest word
    localparam logic [16*32-1:0] ATAN_LUT = {
        32'h0000517C, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2E, 32'h0028BE53,
        32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
        32'h051111D4, 32'h09FB385B, 32'h12E4051D, 32'h20000000
    };

    typedef enum logic [1:0] {
        WRAP_NONE = 2'd0,
        WRAP_DOWN = 2'd1,
        WRAP_UP   = 2'd2
    } wrap_dir_t;

    typedef enum logic {
        ROW_POS,
        ROW_LIMIT
    } row_kind_t;

    typedef struct packed {
        logic        term;
        logic [17:0] travel;
    } travel_res_t;

    typedef struct {
        row_kind_t                    kind;
        logic [31:0]                  x;
        logic [31:0]                  y;
        logic                         nt;
        bit                           typed;
        travel_res_t                  want;
        logic [atld_pkg::MAXT_W-1:0]  limit;
    } stim_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [63:0]                      s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [atld_pkg::TDATA_O_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [atld_pkg::MAXT_W-1:0]      cfg_data;

    // track state as the block should hold it
    logic                             trk_have;
    logic [15:0]                      trk_start;
    logic [15:0]                      trk_prev;
    logic                             trk_wrapped;
    wrap_dir_t                        trk_dir;
    logic [atld_pkg::MAXT_W-1:0]      limit_reg;

    travel_res_t            travel_due [$];
    int                     mismatches;
    int                     idle_cycles;
    bit                     quiet;      // no idling on either side
    bit                     hold_req;   // ask the sink for one long hold-off

    azimuth_travel_limit_detector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Angle of (-x, -y) as a 16-bit turn fraction: normalise, 16 vectoring steps in the
    // first quadrant, fold the quadrant back in, round half up.
    function automatic logic [15:0] azimuth_of(input logic [31:0] px, input logic [31:0] py);
        logic [31:0] ax, ay, big, t1, zq;
        logic [32:0] sum;
        logic        xneg, yneg, uneg, vneg;
        longint      cx, cy, z, dx, dy;
        int          msb, b;
        xneg = px[31];
        yneg = py[31];
        ax   = xneg ? (~px + 32'd1) : px;
        ay   = yneg ? (~py + 32'd1) : py;
        uneg = !xneg && (ax != 0);
        vneg = !yneg && (ay != 0);
        big  = ax | ay;
        if (big == 0)
        begin
            zq = Z_HALF;
        end
        else
        begin
            msb = 0;
            for (b = 0; b < 32; b++)
            begin
                if (big[b])
                    msb = b;
            end
            cx = longint'({32'd0, ax});
            cy = longint'({32'd0, ay});
            if (msb > 29)
            begin
                cx = cx >>> (msb - 29);
                cy = cy >>> (msb - 29);
            end
            else
            begin
                cx = cx <<< (29 - msb);
                cy = cy <<< (29 - msb);
            end
            z = 0;
            for (b = 0; b < 16; b++)
            begin
                dx = cy >>> b;
                dy = cx >>> b;
                if (cy >= 0)
                begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + longint'({32'd0, ATAN_LUT[b*32 +: 32]});
                end
                else
                begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - longint'({32'd0, ATAN_LUT[b*32 +: 32]});
                end
            end
            t1 = z[31:0];
            if (!uneg && !vneg)
                zq = t1;
            else if (uneg && !vneg)
                zq = Z_HALF - t1;
            else if (uneg && vneg)
                zq = Z_HALF + t1;
            else
                zq = 32'd0 - t1;
        end
        sum = {1'b0, zq} + 33'h0_0000_8000;
        return sum[31:16];   // a round-up to a full turn wraps to zero
    endfunction

    // One position through the track state; returns the result it must produce.
    function automatic travel_res_t advance_track(input logic [31:0] px, input logic [31:0] py,
                                                  input logic nt);
        travel_res_t r;
        int          cur, st, diff, delta;
        cur   = int'(azimuth_of(px, py));
        st    = int'(trk_start);
        delta = 0;
        if (!trk_have || nt)
        begin
            trk_start   = cur[15:0];
            trk_prev    = cur[15:0];
            trk_have    = 1'b1;
            trk_wrapped = 1'b0;
            trk_dir     = WRAP_NONE;
        end
        else
        begin
            diff = int'(trk_prev) - cur;
            if (!trk_wrapped)
                delta = (st >= cur) ? st - cur : cur - st;
            else if (trk_dir == WRAP_DOWN)
                delta = TURN + cur - st;
            else if (trk_dir == WRAP_UP)
                delta = TURN - cur + st;
            if (diff >= HALF)
            begin
                trk_wrapped = 1'b1;
                trk_dir     = WRAP_DOWN;
                delta       = TURN + cur - st;
            end
            if (diff <= -HALF)
            begin
                trk_wrapped = 1'b1;
                trk_dir     = WRAP_UP;
                delta       = TURN - cur + st;
            end
            trk_prev = cur[15:0];
        end
        r.term = 1'b0;
        if (delta > int'(limit_reg))
        begin
            trk_wrapped = 1'b0;
            trk_dir     = WRAP_NONE;
            r.term      = 1'b1;
        end
        r.travel = delta[17:0];
        return r;
    endfunction

    function automatic stim_row_t pos_row(input logic [31:0] x, input logic [31:0] y,
                                          input logic nt, input bit typed,
                                          input logic term, input logic [17:0] travel);
        stim_row_t r;
        r.kind  = ROW_POS;
        r.x     = x;
        r.y     = y;
        r.nt    = nt;
        r.typed = typed;
        r.want  = '{term: term, travel: travel};
        r.limit = '0;
        return r;
    endfunction

    function automatic stim_row_t lim_row(input logic [atld_pkg::MAXT_W-1:0] v);
        stim_row_t r;
        r       = pos_row('0, '0, 1'b0, 1'b0, 1'b0, '0);
        r.kind  = ROW_LIMIT;
        r.limit = v;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_position(input logic [31:0] x, input logic [31:0] y, input logic nt,
                                 input bit typed, input travel_res_t want);
        int          gap;
        travel_res_t r;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= nt;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        r = advance_track(x, y, nt);
        travel_due.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Stop offering, let every expected result come out, then wait out the drain margin.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (travel_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_limit(input logic [atld_pkg::MAXT_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        limit_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result sink: a fresh hold-off before each transfer, plus one long hold when asked.
    initial
    begin : result_sink
        int hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            hold = quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Scoreboard: each result against the oldest outstanding prediction.
    always @(posedge clk)
    begin : result_check
        travel_res_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (travel_due.size() == 0)
            begin
                $error("result with nothing outstanding: terminate %0d travel %0d",
                       m_axis_tuser, m_axis_tdata[17:0]);
                mismatches++;
            end
            else
            begin
                w = travel_due.pop_front();
                if (m_axis_tuser !== w.term)
                begin
                    $error("terminate mismatch: expected %0d, got %0d", w.term, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[17:0] !== w.travel)
                begin
                    $error("travel mismatch: expected %0d, got %0d", w.travel,
                           m_axis_tdata[17:0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   rows [$];
        longint      rad, per, u, step, off, side, px, py;
        int          ph, sent, j, len, k;
        bit          ccw;
        logic [atld_pkg::MAXT_W-1:0] lim;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        trk_have      = 1'b0;
        trk_start     = '0;
        trk_prev      = '0;
        trk_wrapped   = 1'b0;
        trk_dir       = WRAP_NONE;
        limit_reg     = atld_pkg::MAXT_RST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // limit at its reset value, one turn
        rows.push_back(pos_row(0, 0, 1'b0, 1'b1, 1'b0, 18'd0));         // first item: origin
        rows.push_back(pos_row(-1, 0, 1'b0, 1'b1, 1'b0, 18'd32768));    // neg x axis, drop wrap
        rows.push_back(pos_row(C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(C_MIN, 0, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(0, C_MAX, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(1, -1, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(0, C_MIN, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(3, 4, 1'b1, 1'b1, 1'b0, 18'd0));          // new track
        // walk 0.75 -> 0.9 -> 0.1 -> 0.5 -> 0.8 turn: drop wrap then past a full turn
        rows.push_back(pos_row(0, 1000, 1'b1, 1'b1, 1'b0, 18'd0));
        rows.push_back(pos_row(-809, 588, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(-809, -588, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(1000, 0, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(-309, 951, 1'b0, 1'b0, 1'b0, '0));
        // 0.1 -> 0.9 -> 0.5 turn: rise wrap
        rows.push_back(pos_row(-809, -588, 1'b1, 1'b1, 1'b0, 18'd0));
        rows.push_back(pos_row(-809, 588, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(1000, 0, 1'b0, 1'b0, 1'b0, '0));
        // zero limit: any movement terminates
        rows.push_back(lim_row('0));
        rows.push_back(pos_row(0, 0, 1'b1, 1'b1, 1'b0, 18'd0));
        rows.push_back(pos_row(-5, 0, 1'b0, 1'b1, 1'b1, 18'd32768));
        rows.push_back(pos_row(0, 0, 1'b0, 1'b1, 1'b1, 18'd65536));      // rise wrap from zero
        // limit above a full turn
        rows.push_back(lim_row('1));
        rows.push_back(pos_row(C_MAX, -1, 1'b0, 1'b0, 1'b0, '0));
        rows.push_back(pos_row(5, C_MIN, 1'b0, 1'b0, 1'b0, '0));

        for (k = 0; k < rows.size(); k++)
        begin
            if (rows[k].kind == ROW_LIMIT)
                set_limit(rows[k].limit);
            else
                push_position(rows[k].x, rows[k].y, rows[k].nt, rows[k].typed, rows[k].want);
        end

        // Random phases: mostly tracks walking round a square rim, some raw noise.
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       lim = '1;
                1:       lim = '0;
                2:       lim = atld_pkg::MAXT_RST;
                3:       lim = atld_pkg::MAXT_W'($urandom_range(0, 131071));
                4:       lim = atld_pkg::MAXT_W'($urandom_range(0, 4000));
                default: lim = 17'h08000;
            endcase
            set_limit(lim);
            quiet = (ph == 2);
            if (ph == 2)
                hold_req = 1'b1;   // sink stalls while the source keeps pushing
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    push_position($urandom, $urandom, ($urandom_range(0, 9) == 0), 1'b0, '0);
                    sent++;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       rad = longint'($urandom_range(1, 100));
                        1:       rad = longint'($urandom_range(100, 100000));
                        2:       rad = longint'($urandom_range(100000, 1 << 20));
                        default: rad = longint'($urandom_range(1 << 20, 1 << 30));
                    endcase
                    per = 8 * rad;   // one turn of rim
                    u   = longint'($urandom) % per;
                    ccw = 1'($urandom_range(0, 1));
                    len = $urandom_range(4, 40);
                    for (j = 0; j < len; j++)
                    begin
                        if (j > 0)
                        begin
                            if ($urandom_range(0, 7) == 0)
                                step = longint'($urandom) % per;
                            else
                                step = longint'($urandom) % (rad * 3 / 2 + 1);
                            u = ccw ? (u + step) % per : (u - step + per) % per;
                        end
                        side = u / (2 * rad);
                        off  = u % (2 * rad);
                        case (side)
                            0:
                            begin
                                px = rad;
                                py = off - rad;
                            end
                            1:
                            begin
                                px = rad - off;
                                py = rad;
                            end
                            2:
                            begin
                                px = -rad;
                                py = rad - off;
                            end
                            default:
                            begin
                                px = off - rad;
                                py = -rad;
                            end
                        endcase
                        // rim point is the direction of (-x, -y)
                        push_position(32'(-px), 32'(-py),
                                      (j == 0) && ($urandom_range(0, 9) != 0), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        quiet = 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
